>>> design/assert_macros.svh
// Assertion macros used by the RTL of the YUV to RGB16 converter (the converter top).
// No dependencies; the clock is clk and the reset is arst_n in every user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked check, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/yrgb_pkg.sv
// Package of the YUV to RGB16 converter: coefficients, format codes,
// shared types and saturating helpers. No dependencies.
package yrgb_pkg;

	typedef enum logic {
		FMT_RGB565 = 1'b0,
		FMT_RGB555 = 1'b1
	} pix_fmt_t;

	// signed 16-bit coefficients, high half of the product is kept
	localparam logic signed [15:0] COEF_Y       = 16'sh253f;
	localparam logic signed [15:0] COEF_U_BLUE  = 16'sh4093;
	localparam logic signed [15:0] COEF_U_GREEN = 16'shf37d;
	localparam logic signed [15:0] COEF_V_RED   = 16'sh3312;
	localparam logic signed [15:0] COEF_V_GREEN = 16'she5fc;

	localparam logic [7:0] LUMA_BLACK = 8'd16;

	typedef logic signed [15:0] term_t;

	typedef struct packed {
		term_t cr;
		term_t cg;
		term_t cb;
	} chroma_terms_t;

	function automatic term_t sat_add16(input term_t a, input term_t b);
		logic signed [16:0] s;
		s = {a[15], a} + {b[15], b};
		if (s[16] != s[15]) begin
			sat_add16 = s[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			sat_add16 = s[15:0];
		end
	endfunction

	function automatic logic [7:0] clamp8(input term_t v);
		if (v[15]) begin
			clamp8 = 8'd0;
		end else if (|v[14:8]) begin
			clamp8 = 8'hff;
		end else begin
			clamp8 = v[7:0];
		end
	endfunction

endpackage

>>> design/yrgb_pixel_pack.sv
// One pixel of the converter: adds luma to chroma terms, saturates,
// clamps to 8 bits and packs as 565 or 555. Depends on yrgb_pkg.
module yrgb_pixel_pack (
	input  yrgb_pkg::term_t         yt,
	input  yrgb_pkg::chroma_terms_t chroma,
	input  yrgb_pkg::pix_fmt_t      fmt,
	output logic [15:0]             pixel
);
	import yrgb_pkg::*;

	logic [7:0] r;
	logic [7:0] g;
	logic [7:0] b;

	always_comb begin
		r = clamp8(sat_add16(yt, chroma.cr));
		g = clamp8(sat_add16(yt, chroma.cg));
		b = clamp8(sat_add16(yt, chroma.cb));
	end

	always_comb begin
		case (fmt)
			FMT_RGB565: pixel = {r[7:3], g[7:2], b[7:3]};
			FMT_RGB555: pixel = {1'b0, r[7:3], g[7:3], b[7:3]};
			default:    pixel = {r[7:3], g[7:2], b[7:3]};
		endcase
	end

endmodule

>>> design/yuv_to_rgb16_converter_top.sv
// YUV pair to two RGB16 pixels.
// Throughput one item (pixel pair) per clock while the output does not stall; three register stages:
// s1 multipliers, s2 green chroma sum, s3 luma sums, clamp and pack.
// A stall stops each full stage that has no empty stage ahead of it; empty stages still fill.
// arst_n clears the stage valid bits and sets pixel_format to RGB565.
// Depends on yrgb_pkg, yrgb_pixel_pack and assert_macros.svh.
module yuv_to_rgb16_converter_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  luma_even,
	input  logic [7:0]  luma_odd,
	input  logic [7:0]  chroma_u,
	input  logic [7:0]  chroma_v,
	input  logic        skip_even,
	input  logic        skip_odd,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pixel_even,
	output logic [15:0] pixel_odd,
	output logic        write_even,
	output logic        write_odd
);
	import yrgb_pkg::*;

	// high 16 bits of a signed product; operands fit in 28 bits of product
	function automatic term_t mul_high(input logic signed [11:0] a,
		input logic signed [15:0] c);
		logic signed [27:0] p;
		p = a * c;
		mul_high = {{4{p[27]}}, p[27:16]};
	endfunction

	// ---------------- configuration register ----------------
	pix_fmt_t pixel_format_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= FMT_RGB565;
		end else if (cfg_wen) begin
			pixel_format_q <= pix_fmt_t'(cfg_wdata);
		end
	end

	// ---------------- stage flow control ----------------
	// A stage moves when it is empty or the next one moves.
	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	assign ready_s3 = !valid_s3 || !out_stall;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// ---------------- stage 1: scale and multiply ----------------
	// luma: max(y - 16, 0) * 8, never negative, 11 bits
	// chroma: (c - 128) * 8, signed 11 bits
	logic [7:0]         ly_even, ly_odd;
	logic signed [11:0] ys_even, ys_odd, us, vs;

	always_comb begin
		ly_even = (luma_even >= LUMA_BLACK) ? (luma_even - LUMA_BLACK) : 8'd0;
		ly_odd  = (luma_odd  >= LUMA_BLACK) ? (luma_odd  - LUMA_BLACK) : 8'd0;
		ys_even = $signed({1'b0, ly_even, 3'b000});
		ys_odd  = $signed({1'b0, ly_odd, 3'b000});
		us      = $signed({~chroma_u[7], ~chroma_u[7], chroma_u[6:0], 3'b000});
		vs      = $signed({~chroma_v[7], ~chroma_v[7], chroma_v[6:0], 3'b000});
	end

	term_t yt_even_s1, yt_odd_s1, cb_s1, cr_s1, cug_s1, cvg_s1;
	logic  write_even_s1, write_odd_s1;

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			yt_even_s1    <= mul_high(ys_even, COEF_Y);
			yt_odd_s1     <= mul_high(ys_odd, COEF_Y);
			cb_s1         <= mul_high(us, COEF_U_BLUE);
			cug_s1        <= mul_high(us, COEF_U_GREEN);
			cr_s1         <= mul_high(vs, COEF_V_RED);
			cvg_s1        <= mul_high(vs, COEF_V_GREEN);
			write_even_s1 <= !skip_even;
			write_odd_s1  <= !skip_odd;
		end
	end

	// ---------------- stage 2: green chroma sum ----------------
	term_t         yt_even_s2, yt_odd_s2;
	chroma_terms_t chroma_s2;
	logic          write_even_s2, write_odd_s2;

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			yt_even_s2    <= yt_even_s1;
			yt_odd_s2     <= yt_odd_s1;
			chroma_s2.cr  <= cr_s1;
			chroma_s2.cg  <= sat_add16(cug_s1, cvg_s1);
			chroma_s2.cb  <= cb_s1;
			write_even_s2 <= write_even_s1;
			write_odd_s2  <= write_odd_s1;
		end
	end

	// ---------------- stage 3: luma add, clamp, pack ----------------
	// Masked pixels still carry their converted value.
	logic [15:0] pix_even_d, pix_odd_d;

	yrgb_pixel_pack u_pack_even (
		.yt     (yt_even_s2),
		.chroma (chroma_s2),
		.fmt    (pixel_format_q),
		.pixel  (pix_even_d)
	);

	yrgb_pixel_pack u_pack_odd (
		.yt     (yt_odd_s2),
		.chroma (chroma_s2),
		.fmt    (pixel_format_q),
		.pixel  (pix_odd_d)
	);

	logic [15:0] pixel_even_s3, pixel_odd_s3;
	logic        write_even_s3, write_odd_s3;
	pix_fmt_t    fmt_s3;

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			pixel_even_s3 <= pix_even_d;
			pixel_odd_s3  <= pix_odd_d;
			write_even_s3 <= write_even_s2;
			write_odd_s3  <= write_odd_s2;
			fmt_s3        <= pixel_format_q;
		end
	end

	assign out_valid  = valid_s3;
	assign pixel_even = pixel_even_s3;
	assign pixel_odd  = pixel_odd_s3;
	assign write_even = write_even_s3;
	assign write_odd  = write_odd_s3;

	// ---------------- checks ----------------
`include "assert_macros.svh"

	`ASSERT_NEXT(a_s1_hold, valid_s1 && !ready_s2, valid_s1 && $stable(cb_s1) && $stable(yt_even_s1), "stage 1 item lost under stall")
	`ASSERT_NEXT(a_s1_moves, valid_s1 && ready_s2, valid_s2, "stage 1 item did not advance")
	`ASSERT_CLK(a_555_top_bit, valid_s3 && fmt_s3 == FMT_RGB555 |-> !pixel_even_s3[15] && !pixel_odd_s3[15], "RGB555 pixel has bit 15 set")

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of yuv_to_rgb16_converter_top: random and directed pixel pairs,
// predicted in a scoreboard class and checked against the output channel.
// Depends on yrgb_pkg and the converter RTL.
module tb;
	import yrgb_pkg::*;

	localparam int RANDOM_PAIRS = 238;      // per random phase, six phases
	localparam int CYCLE_LIMIT  = 200000;   // watchdog, far above the slowest legal run

	// One item of the input channel: a luma pair sharing one chroma sample set.
	typedef struct packed {
		logic [7:0] luma_even;
		logic [7:0] luma_odd;
		logic [7:0] chroma_u;
		logic [7:0] chroma_v;
		logic       skip_even;
		logic       skip_odd;
	} yuv_pair_t;

	// One item of the output channel: two packed pixels and their write enables.
	typedef struct packed {
		logic [15:0] pixel_even;
		logic [15:0] pixel_odd;
		logic        write_even;
		logic        write_odd;
	} rgb_pair_t;

	// Converts accepted pairs into the pixels the block must produce and
	// keeps them in order until the output channel delivers them.
	class rgb_pair_predictor;
		pix_fmt_t  fmt;
		rgb_pair_t awaited[$];
		int        mismatches;

		function new();
			fmt = FMT_RGB565;
			mismatches = 0;
		endfunction

		// upper half of the signed 32-bit product, rounded toward minus infinity
		function int mul_hi(int a, logic signed [15:0] coef);
			int p;
			p = a * int'(coef);
			return p >>> 16;
		endfunction

		function int limit16(int v);
			if (v > 32767) return 32767;
			if (v < -32768) return -32768;
			return v;
		endfunction

		function logic [7:0] limit8(int v);
			if (v < 0) return 8'd0;
			if (v > 255) return 8'd255;
			return 8'(v);
		endfunction

		// luma term, per-channel sums, clamp, then pack in the current format
		function logic [15:0] pack_rgb(logic [7:0] luma, int cr, int cg, int cb);
			int yl;
			int yt;
			logic [7:0] r;
			logic [7:0] g;
			logic [7:0] b;
			yl = int'(luma) - 16;
			if (yl < 0) yl = 0;
			yt = mul_hi(yl * 8, COEF_Y);
			r = limit8(limit16(yt + cr));
			g = limit8(limit16(yt + cg));
			b = limit8(limit16(yt + cb));
			if (fmt == FMT_RGB555) return {1'b0, r[7:3], g[7:3], b[7:3]};
			return {r[7:3], g[7:2], b[7:3]};
		endfunction

		function void note_pair(yuv_pair_t p);
			int u;
			int v;
			int cr;
			int cg;
			int cb;
			rgb_pair_t e;
			u  = (int'(p.chroma_u) - 128) * 8;
			v  = (int'(p.chroma_v) - 128) * 8;
			cb = mul_hi(u, COEF_U_BLUE);
			cr = mul_hi(v, COEF_V_RED);
			cg = limit16(mul_hi(u, COEF_U_GREEN) + mul_hi(v, COEF_V_GREEN));
			// a masked pixel still carries its converted value
			e.pixel_even = pack_rgb(p.luma_even, cr, cg, cb);
			e.pixel_odd  = pack_rgb(p.luma_odd, cr, cg, cb);
			e.write_even = ~p.skip_even;
			e.write_odd  = ~p.skip_odd;
			awaited.push_back(e);
		endfunction

		function void check_pixels(rgb_pair_t got);
			rgb_pair_t e;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pixel pair: even=%h odd=%h write=%b%b",
						got.pixel_even, got.pixel_odd, got.write_even, got.write_odd);
				return;
			end
			e = awaited.pop_front();
			if (got.pixel_even !== e.pixel_even || got.pixel_odd !== e.pixel_odd ||
					got.write_even !== e.write_even || got.write_odd !== e.write_odd) begin
				mismatches++;
				if (mismatches <= 10)
					$display("pixel mismatch: expected even=%h odd=%h write=%b%b, got even=%h odd=%h write=%b%b",
						e.pixel_even, e.pixel_odd, e.write_even, e.write_odd,
						got.pixel_even, got.pixel_odd, got.write_even, got.write_odd);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic        cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  luma_even;
	logic [7:0]  luma_odd;
	logic [7:0]  chroma_u;
	logic [7:0]  chroma_v;
	logic        skip_even;
	logic        skip_odd;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] pixel_even;
	logic [15:0] pixel_odd;
	logic        write_even;
	logic        write_odd;

	int tx_idle_pct;    // chance in percent that the sender skips a cycle
	int rx_idle_pct;    // chance in percent that the receiver stalls a cycle
	int cycles;

	rgb_pair_predictor book = new();

	yuv_to_rgb16_converter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.luma_even (luma_even),
		.luma_odd  (luma_odd),
		.chroma_u  (chroma_u),
		.chroma_v  (chroma_v),
		.skip_even (skip_even),
		.skip_odd  (skip_odd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_even(pixel_even),
		.pixel_odd (pixel_odd),
		.write_even(write_even),
		.write_odd (write_odd)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: stalls independently of out_valid, rate set by the current phase.
	always @(posedge clk) begin
		out_stall <= (rx_idle_pct > 0) && ($urandom_range(99) < rx_idle_pct);
	end

	// Output monitor: values read right after the edge are the ones the DUT saw.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			book.check_pixels({pixel_even, pixel_odd, write_even, write_odd});
	end

	// Offer one item, with random idle cycles ahead of it, and return at the edge
	// that accepts it. Valid stays high between back-to-back items.
	task automatic send_pair(input yuv_pair_t p);
		while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		luma_even <= p.luma_even;
		luma_odd  <= p.luma_odd;
		chroma_u  <= p.chroma_u;
		chroma_v  <= p.chroma_v;
		skip_even <= p.skip_even;
		skip_odd  <= p.skip_odd;
		do
			@(posedge clk);
		while (in_stall);
		// noted in this process so a following drain always sees it
		book.note_pair(p);
	endtask

	// Hold the sender off until every predicted item has come out.
	task automatic drain();
		in_valid <= 1'b0;
		while (book.pending() != 0)
			@(posedge clk);
	endtask

	// Only called with the pipeline empty; the predictor follows the same edge.
	task automatic write_format(input pix_fmt_t f);
		cfg_wen   <= 1'b1;
		cfg_wdata <= f;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		book.fmt = f;
	endtask

	function automatic yuv_pair_t mk_pair(int ye, int yo, int u, int v, int se, int so);
		yuv_pair_t p;
		p.luma_even = 8'(ye);
		p.luma_odd  = 8'(yo);
		p.chroma_u  = 8'(u);
		p.chroma_v  = 8'(v);
		p.skip_even = 1'(se);
		p.skip_odd  = 1'(so);
		return p;
	endfunction

	// Full-range values with extra weight on the rails, black level and neutral chroma.
	function automatic logic [7:0] pick_sample();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'(14 + $urandom_range(3));
			3: return 8'(126 + $urandom_range(4));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic yuv_pair_t random_pair();
		yuv_pair_t p;
		p.luma_even = pick_sample();
		p.luma_odd  = pick_sample();
		p.chroma_u  = pick_sample();
		p.chroma_v  = pick_sample();
		p.skip_even = 1'($urandom_range(1));
		p.skip_odd  = 1'($urandom_range(1));
		return p;
	endfunction

	// Corners: rails, black and below-black luma, neutral and extreme chroma,
	// every skip combination (masked pixels must still carry their value).
	task automatic run_directed();
		send_pair(mk_pair(0, 0, 0, 0, 0, 0));
		send_pair(mk_pair(255, 255, 255, 255, 0, 0));
		send_pair(mk_pair(16, 16, 128, 128, 0, 0));
		send_pair(mk_pair(15, 235, 128, 128, 1, 0));
		send_pair(mk_pair(235, 255, 128, 128, 0, 1));
		send_pair(mk_pair(128, 128, 0, 0, 1, 1));
		send_pair(mk_pair(128, 128, 255, 0, 0, 0));
		send_pair(mk_pair(128, 128, 0, 255, 0, 0));
		send_pair(mk_pair(255, 0, 255, 255, 0, 0));
		send_pair(mk_pair(0, 255, 0, 0, 0, 0));
		send_pair(mk_pair(200, 60, 90, 240, 1, 0));
		send_pair(mk_pair(81, 145, 54, 34, 0, 1));
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wen     = 1'b0;
		cfg_wdata   = 1'b0;
		in_valid    = 1'b0;
		luma_even   = 8'd0;
		luma_odd    = 8'd0;
		chroma_u    = 8'd0;
		chroma_v    = 8'd0;
		skip_even   = 1'b0;
		skip_odd    = 1'b0;
		out_stall   = 1'b0;
		cycles      = 0;
		tx_idle_pct = 8;
		rx_idle_pct = 87;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners in both packings
		write_format(FMT_RGB565);
		run_directed();
		drain();
		write_format(FMT_RGB555);
		run_directed();
		drain();

		// random phases: slow receiver, then slow sender, then full rate,
		// each twice with the packing flipped in between
		for (int mode = 0; mode < 3; mode++) begin
			tx_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 87 : 0;
			rx_idle_pct = (mode == 0) ? 87 : (mode == 1) ? 8 : 0;
			for (int k = 0; k < 2; k++) begin
				write_format(book.fmt == FMT_RGB565 ? FMT_RGB555 : FMT_RGB565);
				repeat (RANDOM_PAIRS) send_pair(random_pair());
				drain();
			end
		end

		// wait out the pipeline depth to catch stray output items
		repeat (8) @(posedge clk);
		if (book.mismatches == 0 && book.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
